FILE: hw/rtl/floppy_controller_positioning_top_defines.svh
// Assertion helpers for the positioning controller. They expect clk and arst_n in scope.
`ifndef FLOPPY_CONTROLLER_POSITIONING_TOP_DEFINES_SVH
`define FLOPPY_CONTROLLER_POSITIONING_TOP_DEFINES_SVH

// cond holds at every clock edge outside reset
`define FDCP_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// cons holds in the cycle after ante
`define FDCP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/fdcp_pkg.sv
package fdcp_pkg;

	localparam int DRIVES_DEF = 4;

	localparam int TDATA_IN_W  = 16;
	localparam int TDATA_OUT_W = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;

	// item modes
	localparam logic [2:0] MODE_TICK       = 3'd0;
	localparam logic [2:0] MODE_SEL_WRITE  = 3'd1;
	localparam logic [2:0] MODE_REG_WRITE  = 3'd2;
	localparam logic [2:0] MODE_REG_READ   = 3'd3;
	localparam logic [2:0] MODE_IRQ_READ   = 3'd4;

	// register select (select register bits 1..0)
	localparam logic [1:0] REG_CMD    = 2'd0;
	localparam logic [1:0] REG_TRACK  = 2'd1;
	localparam logic [1:0] REG_SECTOR = 2'd2;
	localparam logic [1:0] REG_DATA   = 2'd3;

	// command groups (upper nibble)
	localparam logic [3:0] GRP_RESTORE    = 4'h0;
	localparam logic [3:0] GRP_SEEK       = 4'h1;
	localparam logic [3:0] GRP_STEP       = 4'h2;
	localparam logic [3:0] GRP_STEP_U     = 4'h3;
	localparam logic [3:0] GRP_STEP_IN    = 4'h4;
	localparam logic [3:0] GRP_STEP_IN_U  = 4'h5;
	localparam logic [3:0] GRP_STEP_OUT   = 4'h6;
	localparam logic [3:0] GRP_STEP_OUT_U = 4'h7;
	localparam logic [3:0] GRP_FORCE_INT  = 4'hd;
	localparam logic [3:0] GRP_READ_TRACK = 4'he;

	localparam logic [7:0] CMD_IDLE      = 8'hff;
	localparam logic [7:0] STATUS_MASK   = 8'hfc;
	localparam logic [7:0] ST_NOT_READY  = 8'h80;
	localparam logic [7:0] ST_TRACK0     = 8'h04;
	localparam logic [7:0] ST_BUSY       = 8'h01;
	localparam logic [7:0] ST_CLEAR      = 8'h00;
	localparam logic [7:0] ST_RESET      = 8'h04;
	localparam logic [7:0] TRACK_REG_MAX = 8'd254;

	// select register bits
	localparam int SEL_DRV0_BIT   = 2;
	localparam int SEL_DRV1_BIT   = 3;
	localparam int SEL_ENABLE_BIT = 4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_STEP0   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP1   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP2   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP3   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESENT = 3'd5;

	localparam logic [15:0] STEP0_RESET   = 16'd6000;
	localparam logic [15:0] STEP1_RESET   = 16'd12000;
	localparam logic [15:0] STEP2_RESET   = 16'd20000;
	localparam logic [15:0] STEP3_RESET   = 16'd30000;
	localparam logic [7:0]  LIMIT_RESET   = 8'd80;
	localparam logic [3:0]  PRESENT_RESET = 4'hf;

	typedef struct packed {
		logic [3:0][15:0] step_period;
		logic [7:0]       track_limit;
		logic [3:0]       disk_present;
	} cfg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic [2:0] mode;
	} item_t;

	typedef struct packed {
		logic       busy_res;
		logic       irq;
		logic [7:0] read_data;
	} result_t;

	typedef struct packed {
		logic cmd_idle;
		logic status_busy;
	} eng_status_t;

	function automatic logic [7:0] track0_status(input logic [7:0] head);
		return (head == 8'd0) ? ST_TRACK0 : ST_CLEAR;
	endfunction

endpackage

FILE: hw/rtl/fdcp_cfg.sv
module fdcp_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fdcp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fdcp_pkg::CFG_DATA_W-1:0]   cfg_data,
	output fdcp_pkg::cfg_t                    cfg
);

	fdcp_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.step_period[0] <= fdcp_pkg::STEP0_RESET;
			cfg_q.step_period[1] <= fdcp_pkg::STEP1_RESET;
			cfg_q.step_period[2] <= fdcp_pkg::STEP2_RESET;
			cfg_q.step_period[3] <= fdcp_pkg::STEP3_RESET;
			cfg_q.track_limit    <= fdcp_pkg::LIMIT_RESET;
			cfg_q.disk_present   <= fdcp_pkg::PRESENT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				fdcp_pkg::CFG_STEP0:   cfg_q.step_period[0] <= cfg_data;
				fdcp_pkg::CFG_STEP1:   cfg_q.step_period[1] <= cfg_data;
				fdcp_pkg::CFG_STEP2:   cfg_q.step_period[2] <= cfg_data;
				fdcp_pkg::CFG_STEP3:   cfg_q.step_period[3] <= cfg_data;
				fdcp_pkg::CFG_LIMIT:   cfg_q.track_limit    <= cfg_data[7:0];
				fdcp_pkg::CFG_PRESENT: cfg_q.disk_present   <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

endmodule

FILE: hw/rtl/fdcp_engine.sv
module fdcp_engine #(
	parameter int DRIVES = fdcp_pkg::DRIVES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  fdcp_pkg::item_t       item,
	input  fdcp_pkg::cfg_t        cfg,
	output fdcp_pkg::result_t     result,
	output fdcp_pkg::eng_status_t status
);

	localparam int DRV_W = (DRIVES > 1) ? $clog2(DRIVES) : 1;

	logic [7:0]  select_q, track_q, sector_q, data_q, status_q, active_q;
	logic        irq_q, inward_q;
	logic [1:0]  drive_sel_q;
	logic [15:0] wait_q;
	logic [7:0]  head_q [DRIVES];

	logic [7:0]  select_n, track_n, sector_n, data_n, status_n, active_n;
	logic        irq_n, inward_n;
	logic [1:0]  drive_sel_n;
	logic [15:0] wait_n;
	logic        head_we;
	logic [7:0]  head_new;
	logic [7:0]  rd;

	logic [DRV_W-1:0] drv;
	logic [1:0]       present_idx;
	logic             present;
	logic [7:0]       ht, ht_in, ht_out;
	logic [8:0]       ht_inc;
	logic [7:0]       trk_in_upd, trk_in_keep, trk_out_upd;
	logic [3:0]       grp, cgrp;
	logic [7:0]       v;

	assign drv         = (int'(drive_sel_q) < DRIVES) ? drive_sel_q[DRV_W-1:0] : '0;
	assign present_idx = 2'(drv);
	assign present     = cfg.disk_present[present_idx];
	assign ht          = head_q[drv];
	assign ht_inc      = {1'b0, ht} + 9'd1;
	assign ht_in       = (ht_inc > {1'b0, cfg.track_limit}) ? cfg.track_limit : ht_inc[7:0];
	assign ht_out      = (ht != 8'd0) ? ht - 8'd1 : ht;
	// track register saturates at 254 after an inward step, update or not
	assign trk_in_upd  = (track_q >= fdcp_pkg::TRACK_REG_MAX) ? fdcp_pkg::TRACK_REG_MAX
	                                                          : track_q + 8'd1;
	assign trk_in_keep = (track_q > fdcp_pkg::TRACK_REG_MAX) ? fdcp_pkg::TRACK_REG_MAX : track_q;
	assign trk_out_upd = (track_q != 8'd0) ? track_q - 8'd1 : track_q;
	assign grp         = active_q[7:4];
	assign v           = item.data_byte;
	assign cgrp        = v[7:4];

	always_comb begin
		select_n    = select_q;
		track_n     = track_q;
		sector_n    = sector_q;
		data_n      = data_q;
		status_n    = status_q;
		active_n    = active_q;
		irq_n       = irq_q;
		inward_n    = inward_q;
		drive_sel_n = drive_sel_q;
		wait_n      = wait_q;
		head_we     = 1'b0;
		head_new    = ht;
		rd          = 8'd0;

		unique case (item.mode)
			fdcp_pkg::MODE_TICK: begin
				if (active_q != fdcp_pkg::CMD_IDLE) begin
					if (wait_q > 16'd1) begin
						wait_n = wait_q - 16'd1;
					end else begin
						wait_n = 16'd0;
						unique case (grp) inside
							fdcp_pkg::GRP_RESTORE: begin
								if (ht == 8'd0) begin
									track_n  = 8'd0;
									status_n = fdcp_pkg::ST_TRACK0 & fdcp_pkg::STATUS_MASK;
									active_n = fdcp_pkg::CMD_IDLE;
									irq_n    = 1'b1;
								end else begin
									inward_n = 1'b0;
									head_we  = 1'b1;
									head_new = ht_out;
									wait_n   = cfg.step_period[active_q[1:0]];
								end
							end
							fdcp_pkg::GRP_SEEK: begin
								if (track_q == data_q) begin
									status_n = fdcp_pkg::track0_status(ht) & fdcp_pkg::STATUS_MASK;
									active_n = fdcp_pkg::CMD_IDLE;
									irq_n    = 1'b1;
								end else begin
									wait_n  = cfg.step_period[active_q[1:0]];
									head_we = 1'b1;
									if (track_q < data_q) begin
										track_n  = track_q + 8'd1;
										inward_n = 1'b1;
										head_new = ht_in;
									end else begin
										track_n  = track_q - 8'd1;
										inward_n = 1'b0;
										head_new = ht_out;
									end
								end
							end
							fdcp_pkg::GRP_STEP, fdcp_pkg::GRP_STEP_U,
							fdcp_pkg::GRP_STEP_IN, fdcp_pkg::GRP_STEP_IN_U,
							fdcp_pkg::GRP_STEP_OUT, fdcp_pkg::GRP_STEP_OUT_U: begin
								head_we = 1'b1;
								// plain step follows the last direction; bit 4 of the code is update
								if ((grp == fdcp_pkg::GRP_STEP_IN) || (grp == fdcp_pkg::GRP_STEP_IN_U)
										|| ((grp[3:1] == fdcp_pkg::GRP_STEP[3:1]) && inward_q)) begin
									head_new = ht_in;
									track_n  = grp[0] ? trk_in_upd : trk_in_keep;
								end else begin
									head_new = ht_out;
									track_n  = grp[0] ? trk_out_upd : track_q;
								end
								status_n = fdcp_pkg::track0_status(head_new) & fdcp_pkg::STATUS_MASK;
								active_n = fdcp_pkg::CMD_IDLE;
								irq_n    = 1'b1;
							end
							default: active_n = fdcp_pkg::CMD_IDLE;
						endcase
					end
				end
			end
			fdcp_pkg::MODE_SEL_WRITE: begin
				if (v[fdcp_pkg::SEL_ENABLE_BIT]) begin
					if (v[fdcp_pkg::SEL_DRV0_BIT]) drive_sel_n = 2'd0;
					if (v[fdcp_pkg::SEL_DRV1_BIT]) drive_sel_n = 2'd1;
				end
				select_n = v;
			end
			fdcp_pkg::MODE_REG_WRITE: begin
				unique case (select_q[1:0])
					fdcp_pkg::REG_CMD: begin
						irq_n = 1'b0;
						if (!present) begin
							status_n = fdcp_pkg::ST_NOT_READY & fdcp_pkg::STATUS_MASK;
							active_n = fdcp_pkg::CMD_IDLE;
							irq_n    = 1'b1;
						end else begin
							unique case (cgrp) inside
								[fdcp_pkg::GRP_RESTORE:fdcp_pkg::GRP_STEP_OUT_U]: begin
									active_n = v;
									wait_n   = cfg.step_period[v[1:0]];
									status_n = fdcp_pkg::ST_BUSY;
									if (cgrp == fdcp_pkg::GRP_SEEK) track_n = ht;
									if ((cgrp == fdcp_pkg::GRP_STEP_IN)
											|| (cgrp == fdcp_pkg::GRP_STEP_IN_U))
										inward_n = 1'b1;
									if ((cgrp == fdcp_pkg::GRP_STEP_OUT)
											|| (cgrp == fdcp_pkg::GRP_STEP_OUT_U))
										inward_n = 1'b0;
								end
								fdcp_pkg::GRP_FORCE_INT: begin
									status_n = fdcp_pkg::ST_CLEAR;
									active_n = fdcp_pkg::CMD_IDLE;
									if (v[3:0] != 4'd0) irq_n = 1'b1;
								end
								fdcp_pkg::GRP_READ_TRACK: begin
									status_n = fdcp_pkg::ST_CLEAR;
									active_n = fdcp_pkg::CMD_IDLE;
									irq_n    = 1'b1;
								end
								default: ;
							endcase
						end
					end
					fdcp_pkg::REG_TRACK:  track_n  = v;
					fdcp_pkg::REG_SECTOR: sector_n = v;
					fdcp_pkg::REG_DATA:   data_n   = v;
					default: ;
				endcase
			end
			fdcp_pkg::MODE_REG_READ: begin
				unique case (select_q[1:0])
					fdcp_pkg::REG_CMD: begin
						irq_n = 1'b0;
						rd    = status_q;
					end
					fdcp_pkg::REG_TRACK:  rd = track_q;
					fdcp_pkg::REG_SECTOR: rd = sector_q;
					fdcp_pkg::REG_DATA:   rd = data_q;
					default: ;
				endcase
			end
			fdcp_pkg::MODE_IRQ_READ: rd = {7'd0, irq_q};
			default: ;
		endcase
	end

	assign result.read_data = rd;
	assign result.irq       = irq_n;
	assign result.busy_res  = status_n[0];

	assign status.cmd_idle    = (active_q == fdcp_pkg::CMD_IDLE);
	assign status.status_busy = status_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			select_q    <= 8'd0;
			track_q     <= 8'd0;
			sector_q    <= 8'd0;
			data_q      <= 8'd0;
			status_q    <= fdcp_pkg::ST_RESET;
			active_q    <= fdcp_pkg::CMD_IDLE;
			irq_q       <= 1'b0;
			inward_q    <= 1'b1;
			drive_sel_q <= 2'd0;
			wait_q      <= 16'd0;
			for (int i = 0; i < DRIVES; i++) head_q[i] <= 8'd0;
		end else if (fire) begin
			select_q    <= select_n;
			track_q     <= track_n;
			sector_q    <= sector_n;
			data_q      <= data_n;
			status_q    <= status_n;
			active_q    <= active_n;
			irq_q       <= irq_n;
			inward_q    <= inward_n;
			drive_sel_q <= drive_sel_n;
			wait_q      <= wait_n;
			if (head_we) head_q[drv] <= head_new;
		end
	end

endmodule

FILE: hw/rtl/floppy_controller_positioning_top.sv
// channel | dir | transaction carries
// s_*     | in  | one bus access or tick: mode, data_byte
// m_*     | out | one result per item: read_data, irq, busy_res
// cfg_*   | in  | configuration write: register index and data
//
// One item per clock sustained while m_tready holds; an item passes the input register, then the result register.
// The item is registered, runs through the register/command logic combinationally,
// and its result lands in the output register while the state updates.
// A stall on m_* backs up through the output register into the input register.
// Reset (arst_n low) clears all control state and loads configuration defaults.
`include "floppy_controller_positioning_top_defines.svh"

module floppy_controller_positioning_top #(
	parameter int DRIVES = fdcp_pkg::DRIVES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [fdcp_pkg::TDATA_IN_W-1:0]     s_tdata,   // mode[2:0], data_byte[10:3]
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [fdcp_pkg::TDATA_OUT_W-1:0]    m_tdata,   // read_data[7:0], irq[8], busy_res[9]
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [fdcp_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [fdcp_pkg::CFG_DATA_W-1:0]     cfg_data
);

	fdcp_pkg::cfg_t        cfg;
	fdcp_pkg::item_t       item_s1;
	logic                  valid_s1;
	fdcp_pkg::result_t     res_comb, res_q;
	logic                  res_valid_q;
	fdcp_pkg::eng_status_t eng_status;
	logic                  advance;

	assign advance  = valid_s1 && (!res_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) item_s1 <= fdcp_pkg::item_t'(s_tdata[10:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (m_tready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) res_q <= res_comb;
	end

	assign m_tvalid = res_valid_q;
	assign m_tdata  = {6'd0, res_q};

	fdcp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	fdcp_engine #(
		.DRIVES (DRIVES)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (res_comb),
		.status (eng_status)
	);

	`FDCP_ASSERT_ALWAYS(a_busy_tracks_cmd, eng_status.status_busy == !eng_status.cmd_idle, "busy bit out of step with running command")
	`FDCP_ASSERT_NEXT(a_take_fills_s1, s_tvalid && s_tready, valid_s1, "accepted item not held in input register")
	`FDCP_ASSERT_NEXT(a_advance_fills_out, advance, res_valid_q, "processed item left no result")
	`FDCP_ASSERT_NEXT(a_stall_keeps_result, res_valid_q && !m_tready, res_valid_q, "stalled result dropped")

endmodule

FILE: test/floppy_controller_positioning_top_tb.sv
module floppy_controller_positioning_top_tb;
	import fdcp_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int REPORT_MAX    = 10;
	localparam int MAX_GAP       = 11;
	localparam int SETTLE_CYCLES = 4;
	localparam int HOLD_CYCLES   = 150;

	// modes with no function, and the command groups outside the positioning set
	localparam logic [2:0] MODE_SPARE_LO  = 3'd5;
	localparam logic [2:0] MODE_SPARE_HI  = 3'd7;
	localparam logic [3:0] GRP_IGNORED_LO = 4'h8;
	localparam logic [3:0] GRP_LAST       = 4'hf;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [TDATA_IN_W-1:0]  s_tdata;   // mode[2:0], data_byte[10:3]
	logic                   m_tvalid;
	logic                   m_tready;
	logic [TDATA_OUT_W-1:0] m_tdata;   // read_data[7:0], irq[8], busy_res[9]
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	floppy_controller_positioning_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// controller image kept by the testbench
	cfg_t        cfg_model;
	logic [7:0]  sel_q, trk_q, sec_q, dat_q, stat_q, cmd_q;
	logic        irq_q, inward_q;
	logic [1:0]  drv_q;
	logic [7:0]  head_q [DRIVES_DEF];
	logic [15:0] wait_q;

	result_t     expected_results [$];
	int unsigned items_sent      = 0;
	int unsigned results_checked = 0;
	int unsigned mismatch_count  = 0;
	int unsigned configs_applied = 0;
	int unsigned cycle_count     = 0;
	int unsigned hold_request    = 0;
	bit          tx_gaps         = 1'b1;
	bit          rx_gaps         = 1'b1;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				expected_results.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	function automatic void end_command(input logic [7:0] s);
		stat_q = s & STATUS_MASK;
		cmd_q  = CMD_IDLE;
		irq_q  = 1'b1;
	endfunction

	function automatic logic [7:0] head_status();
		return (head_q[drv_q] == 8'd0) ? ST_TRACK0 : ST_CLEAR;
	endfunction

	function automatic void move_head(input logic dir_in);
		if (!dir_in) begin
			if (head_q[drv_q] != 8'd0) head_q[drv_q] = head_q[drv_q] - 8'd1;
		end else if ({1'b0, head_q[drv_q]} + 9'd1 > {1'b0, cfg_model.track_limit}) begin
			// also pulls a head back if the limit was lowered below it
			head_q[drv_q] = cfg_model.track_limit;
		end else begin
			head_q[drv_q] = head_q[drv_q] + 8'd1;
		end
	endfunction

	function automatic void engine_tick();
		logic [3:0] grp;
		logic       dir_in, upd;
		logic [8:0] t;
		if (cmd_q == CMD_IDLE) return;
		if (wait_q > 16'd1) begin
			wait_q = wait_q - 16'd1;
			return;
		end
		wait_q = 16'd0;
		grp = cmd_q[7:4];
		case (grp)
			GRP_RESTORE: begin
				if (head_q[drv_q] == 8'd0) begin
					trk_q = 8'd0;
					end_command(ST_TRACK0);
				end else begin
					inward_q = 1'b0;
					move_head(1'b0);
					wait_q = cfg_model.step_period[cmd_q[1:0]];
				end
			end
			GRP_SEEK: begin
				if (trk_q == dat_q) begin
					end_command(head_status());
				end else begin
					wait_q = cfg_model.step_period[cmd_q[1:0]];
					inward_q = (trk_q < dat_q);
					trk_q = inward_q ? trk_q + 8'd1 : trk_q - 8'd1;
					move_head(inward_q);
				end
			end
			GRP_STEP, GRP_STEP_U, GRP_STEP_IN, GRP_STEP_IN_U, GRP_STEP_OUT, GRP_STEP_OUT_U: begin
				dir_in = (grp == GRP_STEP || grp == GRP_STEP_U) ? inward_q :
					(grp == GRP_STEP_IN || grp == GRP_STEP_IN_U);
				upd = grp[0];   // odd groups update the track register
				move_head(dir_in);
				if (dir_in) begin
					// clamp applies even without update
					t = {1'b0, trk_q} + {8'd0, upd};
					if (t > {1'b0, TRACK_REG_MAX}) t = {1'b0, TRACK_REG_MAX};
					trk_q = t[7:0];
				end else if (upd && trk_q != 8'd0) begin
					trk_q = trk_q - 8'd1;
				end
				end_command(head_status());
			end
			default: cmd_q = CMD_IDLE;
		endcase
	endfunction

	function automatic void issue_command(input logic [7:0] c);
		logic [3:0] grp;
		grp = c[7:4];
		if (!cfg_model.disk_present[drv_q]) begin
			end_command(ST_NOT_READY);
			return;
		end
		if (grp <= GRP_STEP_OUT_U) begin
			cmd_q  = c;
			wait_q = cfg_model.step_period[c[1:0]];
			stat_q = ST_BUSY;
			if (grp == GRP_SEEK) trk_q = head_q[drv_q];
			if (grp == GRP_STEP_IN || grp == GRP_STEP_IN_U) inward_q = 1'b1;
			if (grp == GRP_STEP_OUT || grp == GRP_STEP_OUT_U) inward_q = 1'b0;
		end else if (grp == GRP_FORCE_INT) begin
			if (c[3:0] != 4'd0) begin
				end_command(ST_CLEAR);
			end else begin
				stat_q = ST_CLEAR;
				cmd_q  = CMD_IDLE;
			end
		end else if (grp == GRP_READ_TRACK) begin
			end_command(ST_CLEAR);
		end
	endfunction

	function automatic result_t advance_controller(input item_t it);
		result_t    r;
		logic [7:0] rd;
		logic [7:0] v;
		rd = 8'd0;
		v  = it.data_byte;
		case (it.mode)
			MODE_TICK: engine_tick();
			MODE_SEL_WRITE: begin
				if (v[SEL_ENABLE_BIT]) begin
					if (v[SEL_DRV0_BIT]) drv_q = 2'd0;
					if (v[SEL_DRV1_BIT]) drv_q = 2'd1;
				end
				sel_q = v;
			end
			MODE_REG_WRITE: begin
				case (sel_q[1:0])
					REG_CMD: begin
						irq_q = 1'b0;
						issue_command(v);
					end
					REG_TRACK:  trk_q = v;
					REG_SECTOR: sec_q = v;
					default:    dat_q = v;
				endcase
			end
			MODE_REG_READ: begin
				case (sel_q[1:0])
					REG_CMD: begin
						irq_q = 1'b0;
						rd = stat_q;
					end
					REG_TRACK:  rd = trk_q;
					REG_SECTOR: rd = sec_q;
					default:    rd = dat_q;
				endcase
			end
			MODE_IRQ_READ: rd = {7'd0, irq_q};
			default: ;
		endcase
		r.read_data = rd;
		r.irq       = irq_q;
		r.busy_res  = stat_q[0];
		return r;
	endfunction

	function automatic void check_result(input logic [TDATA_OUT_W-1:0] raw);
		result_t got, want;
		got = raw[9:0];
		results_checked++;
		if (expected_results.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_MAX)
				$display("unexpected result rd=%02h irq=%0b busy=%0b", got.read_data, got.irq,
					got.busy_res);
			return;
		end
		want = expected_results.pop_front();
		if (got.read_data !== want.read_data || got.irq !== want.irq ||
				got.busy_res !== want.busy_res) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_MAX)
				$display("result %0d: expected rd=%02h irq=%0b busy=%0b, got rd=%02h irq=%0b busy=%0b",
					results_checked, want.read_data, want.irq, want.busy_res,
					got.read_data, got.irq, got.busy_res);
		end
	endfunction

	initial begin : result_sink
		int unsigned gap;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = rx_gaps ? $urandom_range(0, MAX_GAP) : 0;
			gap += hold_request;
			hold_request = 0;
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			check_result(m_tdata);
		end
	end

	task automatic send_item(input logic [2:0] mode, input logic [7:0] value);
		item_t it;
		int    gap;
		it.mode      = mode;
		it.data_byte = value;
		gap = tx_gaps ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= TDATA_IN_W'(it);
		do @(posedge clk); while (!s_tready);
		expected_results.push_back(advance_controller(it));
		items_sent++;
	endtask

	task automatic drain(input int extra);
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic apply_config(input cfg_t c);
		logic [CFG_IDX_W-1:0] idx;
		drain(SETTLE_CYCLES);
		for (int i = CFG_STEP0; i <= CFG_PRESENT; i++) begin
			idx = CFG_IDX_W'(i);
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			case (idx)
				CFG_LIMIT:   cfg_data <= {8'h00, c.track_limit};
				CFG_PRESENT: cfg_data <= {12'h000, c.disk_present};
				default:     cfg_data <= c.step_period[idx[1:0]];
			endcase
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		cfg_model = c;
		configs_applied++;
	endtask

	function automatic cfg_t make_cfg(input int max_period, input logic [7:0] limit,
			input logic [3:0] present);
		cfg_t c;
		for (int i = 0; i < 4; i++) c.step_period[i] = 16'($urandom_range(1, max_period));
		c.track_limit  = limit;
		c.disk_present = present;
		return c;
	endfunction

	// spare bits and side are random; drive bits only count with enable set
	function automatic logic [7:0] select_byte(input logic [1:0] regsel, input bit enable,
			input bit drive1);
		logic [7:0] b;
		b = 8'($urandom);
		b[1:0] = regsel;
		b[SEL_ENABLE_BIT] = enable;
		b[SEL_DRV1_BIT] = drive1;
		if (!drive1) b[SEL_DRV0_BIT] = 1'b1;
		return b;
	endfunction

	// target, optional track preset, command, ticks with reads mixed in, then status and track reads
	task automatic run_command_sequence();
		bit         drive1;
		logic [3:0] grp;
		logic [7:0] trk;
		drive1 = 1'($urandom_range(0, 1));
		send_item(MODE_SEL_WRITE, select_byte(REG_DATA, 1'b1, drive1));
		send_item(MODE_REG_WRITE, ($urandom_range(0, 3) == 0) ? 8'($urandom) :
			8'($urandom_range(0, 12)));
		if ($urandom_range(0, 2) == 0) begin
			case ($urandom_range(0, 3))
				0:       trk = 8'd0;
				1:       trk = TRACK_REG_MAX;
				2:       trk = 8'hff;
				default: trk = 8'($urandom);
			endcase
			send_item(MODE_SEL_WRITE, select_byte(REG_TRACK, 1'($urandom_range(0, 1)), drive1));
			send_item(MODE_REG_WRITE, trk);
		end
		send_item(MODE_SEL_WRITE, select_byte(REG_CMD, 1'($urandom_range(0, 1)), drive1));
		grp = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(GRP_IGNORED_LO, GRP_LAST)) :
			4'($urandom_range(GRP_RESTORE, GRP_STEP_OUT_U));
		send_item(MODE_REG_WRITE, {grp, 4'($urandom)});
		repeat ($urandom_range(1, 40)) begin
			case ($urandom_range(0, 9))
				0:       send_item(MODE_REG_READ, 8'($urandom));
				1:       send_item(MODE_IRQ_READ, 8'($urandom));
				default: send_item(MODE_TICK, 8'($urandom));
			endcase
		end
		send_item(MODE_REG_READ, 8'($urandom));
		send_item(MODE_SEL_WRITE, select_byte(REG_TRACK, 1'b0, drive1));
		send_item(MODE_REG_READ, 8'($urandom));
	endtask

	task automatic random_phase(input cfg_t c, input int n_items, input bit gaps);
		int unsigned start;
		apply_config(c);
		tx_gaps = gaps;
		rx_gaps = gaps;
		start = items_sent;
		while (items_sent - start < n_items) begin
			if ($urandom_range(0, 4) == 0) send_item(3'($urandom), 8'($urandom));
			else run_command_sequence();
		end
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
	endtask

	task automatic test_register_access();
		send_item(MODE_REG_READ, 8'hff);   // reset status
		send_item(MODE_IRQ_READ, 8'h00);
		send_item(MODE_SEL_WRITE, {2'b11, 1'b1, 1'b1, 1'b1, 1'b1, REG_TRACK});
		send_item(MODE_REG_WRITE, 8'hff);
		send_item(MODE_REG_READ, 8'h00);
		send_item(MODE_SEL_WRITE, {6'd0, REG_SECTOR});
		send_item(MODE_REG_WRITE, 8'hff);
		send_item(MODE_REG_READ, 8'h00);
		send_item(MODE_SEL_WRITE, {6'd0, REG_DATA});
		send_item(MODE_REG_WRITE, 8'h00);
		send_item(MODE_REG_READ, 8'hff);
		for (int m = MODE_SPARE_LO; m <= MODE_SPARE_HI; m++) send_item(3'(m), 8'hff);
	endtask

	task automatic test_positioning();
		cfg_t c;
		c = make_cfg(1, 8'd3, 4'hf);
		c.step_period[1] = 16'd2;
		c.step_period[3] = 16'hffff;
		apply_config(c);
		send_item(MODE_SEL_WRITE, {3'b000, 1'b1, 1'b0, 1'b1, REG_DATA});   // drive 0
		send_item(MODE_REG_WRITE, 8'd2);
		send_item(MODE_SEL_WRITE, {6'd0, REG_CMD});
		send_item(MODE_REG_WRITE, {GRP_SEEK, 4'h0});
		repeat (3) send_item(MODE_TICK, 8'h00);
		send_item(MODE_REG_READ, 8'h00);
		send_item(MODE_REG_WRITE, {GRP_STEP_IN_U, 4'h1});
		repeat (2) send_item(MODE_TICK, 8'hff);
		// head sits on the limit: no further inward motion
		send_item(MODE_REG_WRITE, {GRP_STEP_IN, 4'h0});
		send_item(MODE_TICK, 8'h00);
		send_item(MODE_REG_WRITE, {GRP_STEP, 4'h0});
		send_item(MODE_TICK, 8'h00);
		send_item(MODE_REG_WRITE, {GRP_STEP_OUT_U, 4'h0});
		send_item(MODE_TICK, 8'h00);
		send_item(MODE_REG_WRITE, {GRP_STEP_OUT, 4'h0});
		send_item(MODE_TICK, 8'h00);
		send_item(MODE_REG_WRITE, {GRP_RESTORE, 4'h0});
		repeat (3) send_item(MODE_TICK, 8'h00);
		send_item(MODE_REG_READ, 8'h00);
		send_item(MODE_IRQ_READ, 8'h00);
	endtask

	task automatic test_special_codes();
		send_item(MODE_REG_WRITE, {GRP_IGNORED_LO, 4'hf});
		send_item(MODE_REG_WRITE, {GRP_LAST, 4'hf});
		send_item(MODE_REG_WRITE, {GRP_STEP_IN, 4'h3});   // longest period, stays busy
		send_item(MODE_TICK, 8'h00);
		send_item(MODE_REG_READ, 8'h00);
		send_item(MODE_REG_WRITE, {GRP_FORCE_INT, 4'h0});
		send_item(MODE_IRQ_READ, 8'h00);
		send_item(MODE_REG_WRITE, {GRP_STEP_OUT_U, 4'h3});
		send_item(MODE_REG_WRITE, {GRP_FORCE_INT, 4'h8});
		send_item(MODE_REG_WRITE, {GRP_READ_TRACK, 4'h0});
		send_item(MODE_IRQ_READ, 8'h00);
	endtask

	task automatic test_no_medium();
		apply_config(make_cfg(1, 8'd255, 4'h0));
		send_item(MODE_REG_WRITE, {GRP_RESTORE, 4'h0});
		send_item(MODE_REG_READ, 8'h00);
		send_item(MODE_REG_WRITE, {GRP_FORCE_INT, 4'h0});
		send_item(MODE_IRQ_READ, 8'h00);
		// drive 0 empty, drive 1 loaded
		apply_config(make_cfg(1, 8'd255, 4'b1110));
		send_item(MODE_SEL_WRITE, {3'b000, 1'b1, 1'b1, 1'b0, REG_CMD});
		send_item(MODE_REG_WRITE, {GRP_STEP_IN, 4'h0});
		repeat (2) send_item(MODE_TICK, 8'h00);
		send_item(MODE_REG_READ, 8'h00);
	endtask

	task automatic test_random_phases();
		cfg_t c;
		random_phase(make_cfg(1, 8'd255, 4'hf), 110, 1'b1);
		random_phase(make_cfg(4, 8'd1, 4'b0101), 110, 1'b1);
		random_phase(make_cfg(3, 8'($urandom_range(2, 20)), 4'hf), 110, 1'b0);
		random_phase(make_cfg(6, 8'($urandom_range(1, 255)), 4'($urandom)), 110, 1'b1);
		c = make_cfg(2, 8'd12, 4'hf);
		c.step_period[2] = 16'hffff;
		random_phase(c, 110, 1'b1);
	endtask

	// output stalled while input keeps offering, then a full pause on the input side and a gapped run
	task automatic test_backpressure();
		int unsigned start;
		apply_config(make_cfg(1, 8'd40, 4'hf));
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		hold_request = HOLD_CYCLES;
		start = items_sent;
		while (items_sent - start < 40) run_command_sequence();
		drain(0);
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		start = items_sent;
		while (items_sent - start < 20) run_command_sequence();
	endtask

	initial begin
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		cfg_model.step_period[0] = STEP0_RESET;
		cfg_model.step_period[1] = STEP1_RESET;
		cfg_model.step_period[2] = STEP2_RESET;
		cfg_model.step_period[3] = STEP3_RESET;
		cfg_model.track_limit    = LIMIT_RESET;
		cfg_model.disk_present   = PRESENT_RESET;
		sel_q    = 8'd0;
		trk_q    = 8'd0;
		sec_q    = 8'd0;
		dat_q    = 8'd0;
		stat_q   = ST_RESET;
		cmd_q    = CMD_IDLE;
		irq_q    = 1'b0;
		inward_q = 1'b1;
		drv_q    = 2'd0;
		wait_q   = 16'd0;
		for (int d = 0; d < DRIVES_DEF; d++) head_q[d] = 8'd0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_access();
		test_positioning();
		test_special_codes();
		test_no_medium();
		test_random_phases();
		test_backpressure();
		drain(8);
		$display("%0d bus accesses and ticks sent, %0d results compared, %0d mismatches",
			items_sent, results_checked, mismatch_count);
		$display("register file, all positioning commands, force interrupt, no medium, clamps; "
			, "%0d configurations", configs_applied);
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
